FILE: rtl/core/ordered_list_engine_unit_assert.svh
`ifndef ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define OLEU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list engine check failed");
`define OLEU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list engine check failed");
`else
`define OLEU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define OLEU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/oleu_pkg.sv
package oleu_pkg;

   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FUNC_SORTED     = 3'd2;
   localparam logic [2:0] FUNC_POP        = 3'd3;
   localparam logic [2:0] FUNC_DELETE     = 3'd4;

   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_SORTED,
      OP_POP,
      OP_DELETE,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_EMPTY,
      ST_FULL,
      ST_NOT_FOUND
   } status_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
   } cmd_type;

endpackage

FILE: rtl/core/ordered_list_engine_unit.sv
// Flow: the execute sequencer takes one transaction at a time from the queue:
// dequeue (S_IDLE), per-cell compare (S_CMP), then shift and commit (S_EXEC),
// which waits while the result port stalls; a 2-entry queue keeps the
// request side open while the back end works or the result port stalls.
// Reset: synchronous, active high; empties the list and drops queued work.
module ordered_list_engine_unit #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_popped,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic               rsp_is_empty
);
   import oleu_pkg::*;

   `include "ordered_list_engine_unit_assert.svh"

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   oleu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_value (req_value),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_cmd     (q_cmd)
   );

   oleu_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_cmd        (q_cmd),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_popped   (rsp_popped),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty)
   );

   `OLEU_ASSERT_IMPLY(a_pop_needs_entry, clock, reset, q_pop, q_valid)
   `OLEU_ASSERT_NEXT(a_accept_fills_queue, clock, reset, req_valid && req_ready, q_valid)
   `OLEU_ASSERT_IMPLY(a_empty_pop_result, clock, reset,
      rsp_valid && (rsp_status == ST_EMPTY), (rsp_popped == INT_MIN) && rsp_is_empty)
   `OLEU_ASSERT_IMPLY(a_full_not_empty, clock, reset,
      rsp_valid && (rsp_status == ST_FULL), !rsp_is_empty)

endmodule

FILE: rtl/core/oleu_front.sv
module oleu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_value,
   output logic               q_valid,
   input  logic               q_pop,
   output oleu_pkg::cmd_type  q_cmd
);
   import oleu_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls_cmd;
   logic       push;
   logic       pop;

   // classify the request code
   always_comb begin
      cls_cmd.value = req_value;
      case (req_func)
         FUNC_PUSH_FRONT: cls_cmd.op = OP_PUSH_FRONT;
         FUNC_PUSH_BACK:  cls_cmd.op = OP_PUSH_BACK;
         FUNC_SORTED:     cls_cmd.op = OP_SORTED;
         FUNC_POP:        cls_cmd.op = OP_POP;
         FUNC_DELETE:     cls_cmd.op = OP_DELETE;
         default:         cls_cmd.op = OP_NOP;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls_cmd;
      end
   end

endmodule

FILE: rtl/core/oleu_back.sv
module oleu_back #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  oleu_pkg::cmd_type  q_cmd,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_popped,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic               rsp_is_empty
);
   import oleu_pkg::*;

   localparam int UW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_EXEC
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [UW-1:0]      used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] popped_ff, popped_in;
   status_type         status_ff, status_in;
   logic               empty_ff, empty_in;
   logic [CAPACITY-1:0] flag_ff, flag_in;
   logic [CAPACITY-1:0] mask;

   logic signed [31:0] entries_ff [CAPACITY];

   logic out_free;
   logic commit;
   logic is_ins;
   logic is_full;
   logic found;
   logic do_ins;
   logic do_rem;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == S_EXEC) && out_free;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign is_ins   = (cmd_ff.op == OP_PUSH_FRONT) || (cmd_ff.op == OP_PUSH_BACK) ||
                     (cmd_ff.op == OP_SORTED);
   assign is_full  = (used_ff == UW'(CAPACITY));
   assign found    = |flag_ff;
   assign do_ins   = is_ins && !is_full;
   assign do_rem   = ((cmd_ff.op == OP_POP) || (cmd_ff.op == OP_DELETE)) && found;

   // each cell flags where the operation lands; the mask marks cells that move
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_val;
      logic signed [31:0] right_val;
      logic               head;
      logic               is_used;
      logic               at_end;

      if (i == 0) begin : g_first
         assign left_val = cmd_ff.value;
         assign head     = 1'b1;
         assign mask[i]  = flag_ff[i];
      end else begin : g_rest
         assign left_val = entries_ff[i-1];
         assign head     = !mask[i-1];
         assign mask[i]  = mask[i-1] | flag_ff[i];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_val = entries_ff[i];
      end else begin : g_inner
         assign right_val = entries_ff[i+1];
      end

      assign is_used = (UW'(i) < used_ff);
      assign at_end  = (UW'(i) == used_ff);

      always_comb begin
         case (cmd_ff.op)
            OP_PUSH_FRONT: flag_in[i] = (i == 0);
            OP_PUSH_BACK:  flag_in[i] = at_end;
            OP_SORTED:     flag_in[i] = (is_used && !(entries_ff[i] < cmd_ff.value)) ||
                                        at_end;
            OP_POP:        flag_in[i] = (i == 0) && (used_ff != '0);
            OP_DELETE:     flag_in[i] = is_used && (entries_ff[i] == cmd_ff.value);
            default:       flag_in[i] = 1'b0;
         endcase
      end

      // shift right on insert, left on removal
      always_ff @(posedge clock) begin
         if (commit && mask[i]) begin
            if (do_ins) begin
               entries_ff[i] <= head ? cmd_ff.value : left_val;
            end else if (do_rem) begin
               entries_ff[i] <= right_val;
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      popped_in    = popped_ff;
      status_in    = status_ff;
      empty_in     = empty_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_cmd;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               used_in      = used_ff + UW'(do_ins) - UW'(do_rem);
               rsp_valid_in = 1'b1;
               empty_in     = (used_in == '0);
               popped_in    = '0;
               status_in    = ST_OK;
               if (is_ins && is_full) begin
                  status_in = ST_FULL;
               end else if (cmd_ff.op == OP_POP) begin
                  if (found) begin
                     popped_in = entries_ff[0];
                  end else begin
                     popped_in = INT_MIN;
                     status_in = ST_EMPTY;
                  end
               end else if ((cmd_ff.op == OP_DELETE) && !found) begin
                  status_in = ST_NOT_FOUND;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      empty_ff  <= empty_in;
      if (state_ff == S_CMP) begin
         flag_ff <= flag_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_popped   = popped_ff;
   assign rsp_status   = status_ff;
   assign rsp_count    = 5'(used_ff);
   assign rsp_is_empty = empty_ff;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

import oleu_pkg::*;

typedef logic signed [31:0] word_type;

typedef struct {
   word_type   popped;
   status_type status;
   logic [4:0] count;
   logic       is_empty;
} list_result_type;

class list_scoreboard;
   word_type        table_q[$];
   list_result_type expected_q[$];
   int              capacity;
   int              failures;

   function new(int cap);
      capacity = cap;
      failures = 0;
   endfunction

   function int size();
      return table_q.size();
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Apply one accepted transaction to the shadow list and queue its result.
   function void note_request(logic [2:0] func, word_type value);
      list_result_type r;
      int              pos;
      r.popped = '0;
      r.status = ST_OK;
      case (func)
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK, FUNC_SORTED: begin
            if (table_q.size() >= capacity) begin
               r.status = ST_FULL;
            end else if (func == FUNC_PUSH_FRONT) begin
               table_q.push_front(value);
            end else if (func == FUNC_PUSH_BACK) begin
               table_q.push_back(value);
            end else begin
               pos = 0;
               while (pos < table_q.size() && table_q[pos] < value) pos++;
               table_q.insert(pos, value);
            end
         end
         FUNC_POP: begin
            if (table_q.size() == 0) begin
               r.popped = INT_MIN;
               r.status = ST_EMPTY;
            end else begin
               r.popped = table_q.pop_front();
            end
         end
         FUNC_DELETE: begin
            pos = 0;
            while (pos < table_q.size() && table_q[pos] != value) pos++;
            if (pos < table_q.size()) table_q.delete(pos);
            else r.status = ST_NOT_FOUND;
         end
         default: ;
      endcase
      r.count    = 5'(table_q.size());
      r.is_empty = (table_q.size() == 0);
      expected_q.push_back(r);
   endfunction

   function void check_result(word_type popped, logic [1:0] status, logic [4:0] count,
                              logic is_empty);
      list_result_type r;
      if (expected_q.size() == 0) begin
         $display("%0t: result with nothing expected, popped %0d status %0d count %0d",
                  $time, popped, status, count);
         failures++;
         return;
      end
      r = expected_q.pop_front();
      if (popped !== r.popped) begin
         $display("%0t: popped mismatch, expected %0d, actual %0d", $time, r.popped, popped);
         failures++;
      end
      if (status !== r.status) begin
         $display("%0t: status mismatch, expected %0d, actual %0d", $time, r.status, status);
         failures++;
      end
      if (count !== r.count) begin
         $display("%0t: count mismatch, expected %0d, actual %0d", $time, r.count, count);
         failures++;
      end
      if (is_empty !== r.is_empty) begin
         $display("%0t: is_empty mismatch, expected %0d, actual %0d", $time, r.is_empty,
                  is_empty);
         failures++;
      end
   endfunction
endclass

module tb_top;
   localparam int         LIST_CAPACITY    = 16;
   localparam int         HOLD_OFF_CYCLES  = 80;
   localparam int         NUM_PHASES       = 6;
   localparam int         PHASE_ITEMS      = 250;
   localparam int         SETTLE_CYCLES    = 8;
   localparam logic [2:0] FUNC_UNUSED_MIN  = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_MAX  = 3'd7;
   localparam word_type   WORD_MAX         = 32'sh7FFF_FFFF;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func     = FUNC_PUSH_FRONT;
   word_type    req_value    = '0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   word_type    rsp_popped;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_count;
   logic        rsp_is_empty;

   list_scoreboard sb;

   int gap_pct      = 0;
   int stall_pct    = 0;
   bit hold_off_req = 1'b0;

   ordered_list_engine_unit #(.CAPACITY(LIST_CAPACITY)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_popped   (rsp_popped),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Offer one transaction and hold it until the engine takes it.
   task automatic send_item(input logic [2:0] func, input word_type value);
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_request(func, value);
   endtask

   task automatic maybe_gap();
      int n;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         n = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every queued result is back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic word_type pick_value();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 4) return $signed($urandom_range(0, 15)) - 8;
      if (mode == 4) begin
         case ($urandom_range(0, 3))
            0: return INT_MIN;
            1: return WORD_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic word_type pick_delete_value();
      if (sb.size() != 0 && $urandom_range(0, 9) < 7)
         return sb.table_q[$urandom_range(0, sb.size() - 1)];
      return pick_value();
   endfunction

   task automatic send_random(input int insert_pct);
      int         r;
      logic [2:0] func;
      word_type   value;
      r = $urandom_range(0, 99);
      value = pick_value();
      if (r < 3) begin
         func = 3'($urandom_range(FUNC_UNUSED_MIN, FUNC_UNUSED_MAX));
      end else if (r < insert_pct) begin
         func = 3'($urandom_range(FUNC_PUSH_FRONT, FUNC_SORTED));
      end else if (r < insert_pct + (100 - insert_pct) / 2) begin
         func  = FUNC_POP;
         value = $urandom;
      end else begin
         func  = FUNC_DELETE;
         value = pick_delete_value();
      end
      send_item(func, value);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_popped, rsp_status, rsp_count, rsp_is_empty);
   end

   initial begin
      int n;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            n = $urandom_range(1, 5);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int insert_mix[NUM_PHASES] = '{60, 40, 75, 30, 55, 50};
      int gap_mix[NUM_PHASES]    = '{10, 30, 0, 20, 10, 0};
      int stall_mix[NUM_PHASES]  = '{20, 10, 30, 0, 15, 0};
      sb = new(LIST_CAPACITY);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty-list corner cases
      send_item(FUNC_POP, 32'sh1234_5678);
      send_item(FUNC_DELETE, '0);
      send_item(FUNC_UNUSED_MAX, -1);
      // extremes at both ends and sorted placement around them
      send_item(FUNC_PUSH_BACK, WORD_MAX);
      send_item(FUNC_PUSH_FRONT, INT_MIN);
      send_item(FUNC_SORTED, '0);
      send_item(FUNC_SORTED, -1);
      send_item(FUNC_SORTED, WORD_MAX);
      send_item(FUNC_SORTED, INT_MIN);
      send_item(FUNC_PUSH_BACK, 32'sh5555_5555);
      send_item(FUNC_PUSH_FRONT, 32'shAAAA_AAAA);
      send_item(FUNC_DELETE, WORD_MAX);
      send_item(FUNC_DELETE, 32'sd12345);
      send_item(FUNC_POP, '0);
      // fill up, then hit the full list with every insert flavor
      while (sb.size() < LIST_CAPACITY) send_item(FUNC_SORTED, $urandom);
      send_item(FUNC_PUSH_FRONT, 32'sd7);
      send_item(FUNC_PUSH_BACK, 32'sd7);
      send_item(FUNC_SORTED, 32'sd7);
      send_item(FUNC_UNUSED_MIN, WORD_MAX);
      send_item(FUNC_DELETE, sb.table_q[sb.size() - 1]);
      send_item(FUNC_POP, '0);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         gap_pct   = gap_mix[p];
         stall_pct = stall_mix[p];
         if (p == 2) hold_off_req = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            maybe_gap();
            send_random(insert_mix[p]);
         end
         if (p == 3) drain();
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
